/* rtl/double_hash_table_assert.svh */
// Assertion macros used by the double hash table top level.
`ifndef DOUBLE_HASH_TABLE_ASSERT_SVH
`define DOUBLE_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`ifndef SYNTH
`define DHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("double_hash_table: same-cycle check failed");
`else
`define DHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

// Next-cycle implication, checked outside reset.
`ifndef SYNTH
`define DHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("double_hash_table: next-cycle check failed");
`else
`define DHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/dht_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and types of the double hash table.
package dht_pkg;

    localparam int CAPACITY   = 64;
    localparam int BKT_W      = $clog2(CAPACITY);
    localparam int SIZE_W     = 7;
    localparam int KEY_W      = 31;
    localparam int MIN_SIZE   = 3;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_SEARCH = 2'd1;
    localparam logic [1:0] KIND_PROBE  = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_PROBED    = 3'd4;
    localparam logic [2:0] ST_READ      = 3'd5;

    // Key memory port control.
    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [BKT_W-1:0] addr;
    } dht_ram_ctl_t;

    // Remainder unit results.
    typedef struct packed {
        logic             done;
        logic [BKT_W-1:0] rem_n;
        logic [BKT_W-1:0] rem_m;
    } dht_mod_res_t;

endpackage

/* rtl/dht_key_ram.sv */
`timescale 1ns / 1ps
// Single-port key memory with a registered read.
module dht_key_ram (
    input  logic                           aclk,
    input  dht_pkg::dht_ram_ctl_t          ctl,
    input  logic [dht_pkg::KEY_W-1:0]      wr_data,
    output logic [dht_pkg::KEY_W-1:0]      rd_data
);

    logic [dht_pkg::KEY_W-1:0] mem [dht_pkg::CAPACITY];
    logic [dht_pkg::KEY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[ctl.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/dht_mod_unit.sv */
`timescale 1ns / 1ps
// Bit-serial remainder unit: key mod n and key mod (n - 2), one key bit per cycle.
module dht_mod_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [dht_pkg::KEY_W-1:0]      key,
    input  logic [dht_pkg::SIZE_W-1:0]     n,
    output dht_pkg::dht_mod_res_t          res
);

    localparam int CNT_W = $clog2(dht_pkg::KEY_W);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [dht_pkg::KEY_W-1:0]     key_reg, key_next;
    logic [dht_pkg::SIZE_W-1:0]    dn_reg, dn_next;
    logic [dht_pkg::SIZE_W-1:0]    dm_reg, dm_next;
    logic [dht_pkg::SIZE_W-1:0]    rn_reg, rn_next;
    logic [dht_pkg::SIZE_W-1:0]    rm_reg, rm_next;
    logic [dht_pkg::SIZE_W:0]      tn, tm;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        key_next  = key_reg;
        dn_next   = dn_reg;
        dm_next   = dm_reg;
        rn_next   = rn_reg;
        rm_next   = rm_reg;
        // Shift the next key bit into both partial remainders.
        tn = {rn_reg, key_reg[dht_pkg::KEY_W-1]};
        tm = {rm_reg, key_reg[dht_pkg::KEY_W-1]};
        if (tn >= {1'b0, dn_reg}) begin
            tn = tn - {1'b0, dn_reg};
        end
        if (tm >= {1'b0, dm_reg}) begin
            tm = tm - {1'b0, dm_reg};
        end
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            key_next  = key;
            dn_next   = n;
            dm_next   = n - dht_pkg::SIZE_W'(2);
            rn_next   = '0;
            rm_next   = '0;
        end else if (busy_reg) begin
            rn_next  = tn[dht_pkg::SIZE_W-1:0];
            rm_next  = tm[dht_pkg::SIZE_W-1:0];
            key_next = {key_reg[dht_pkg::KEY_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(dht_pkg::KEY_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        key_reg <= key_next;
        dn_reg  <= dn_next;
        dm_reg  <= dm_next;
        rn_reg  <= rn_next;
        rm_reg  <= rm_next;
    end

    assign res.done  = done_reg;
    assign res.rem_n = rn_reg[dht_pkg::BKT_W-1:0];
    assign res.rem_m = rm_reg[dht_pkg::BKT_W-1:0];

endmodule

/* rtl/double_hash_table.sv */
`timescale 1ns / 1ps
// Top level: double hashing table with stream ports and a register port.
// One item at a time: insert, search and probe path pass the key through the remainder unit,
// then read (S_PRD) and check (S_PCHK) one bucket per probe until the item ends; the next
// input is taken once the last result is registered. A bucket read passes S_RRD and S_RCHK.
// A stalled result holds the probe walk.
// Reset (synchronous, active low) clears all valid bits at once and sets table_size to 64.
module double_hash_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // key [30:0], bucket_index [36:31], zero [39:37]
    input  logic [1:0]  s_tuser,   // kind [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // bucket [5:0], value [36:6], occupied [37], zero [39:38]
    output logic [2:0]  m_tuser,   // status [2:0]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "double_hash_table_assert.svh"

    localparam int BW = dht_pkg::BKT_W;
    localparam int SW = dht_pkg::SIZE_W;
    localparam int KW = dht_pkg::KEY_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_PRD  = 3'd2;
    localparam logic [2:0] S_PCHK = 3'd3;
    localparam logic [2:0] S_RRD  = 3'd4;
    localparam logic [2:0] S_RCHK = 3'd5;

    logic [2:0]                 state_reg, state_next;
    logic [1:0]                 kind_reg, kind_next;
    logic [KW-1:0]              key_reg, key_next;
    logic [BW-1:0]              bidx_reg, bidx_next;
    logic [SW-1:0]              n_reg, n_next;
    logic [BW-1:0]              bucket_reg, bucket_next;
    logic [BW-1:0]              step_reg, step_next;
    logic [SW-1:0]              cnt_reg, cnt_next;
    logic                       vld_q_reg, vld_q_next;
    logic [dht_pkg::CAPACITY-1:0] valid_reg, valid_next;
    logic [SW-1:0]              table_size_reg, table_size_next;

    logic                       m_tvalid_reg, m_tvalid_next;
    logic [2:0]                 m_status_reg, m_status_next;
    logic [BW-1:0]              m_bucket_reg, m_bucket_next;
    logic [KW-1:0]              m_value_reg, m_value_next;
    logic                       m_occupied_reg, m_occupied_next;
    logic                       m_last_reg, m_last_next;

    logic                       in_xfer, out_free, cfg_wr;
    logic [SW-1:0]              n_clamp;
    logic [SW-1:0]              sum;
    logic                       hit, last_probe;
    logic [KW-1:0]              rd_key;
    dht_pkg::dht_ram_ctl_t      ram_ctl;
    dht_pkg::dht_mod_res_t      mod_res;

    dht_key_ram u_key_ram (
        .aclk    (aclk),
        .ctl     (ram_ctl),
        .wr_data (key_reg),
        .rd_data (rd_key)
    );

    dht_mod_unit u_mod_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_xfer && (s_tuser != dht_pkg::KIND_READ)),
        .key     (s_tdata[KW-1:0]),
        .n       (n_clamp),
        .res     (mod_res)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Register port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {25'd0, table_size_reg} : 32'd0;

    always_comb begin
        if (table_size_reg < SW'(dht_pkg::MIN_SIZE)) begin
            n_clamp = SW'(dht_pkg::MIN_SIZE);
        end else if (table_size_reg > SW'(dht_pkg::CAPACITY)) begin
            n_clamp = SW'(dht_pkg::CAPACITY);
        end else begin
            n_clamp = table_size_reg;
        end
    end

    assign sum        = {1'b0, bucket_reg} + {1'b0, step_reg};
    assign hit        = vld_q_reg && (rd_key == key_reg);
    assign last_probe = ((cnt_reg + SW'(1)) == n_reg);

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        bidx_next       = bidx_reg;
        n_next          = n_reg;
        bucket_next     = bucket_reg;
        step_next       = step_reg;
        cnt_next        = cnt_reg;
        vld_q_next      = vld_q_reg;
        valid_next      = valid_reg;
        table_size_next = cfg_wr ? pwdata[SW-1:0] : table_size_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_bucket_next   = m_bucket_reg;
        m_value_next    = m_value_reg;
        m_occupied_next = m_occupied_reg;
        m_last_next     = m_last_reg;
        ram_ctl.rd_en   = 1'b0;
        ram_ctl.wr_en   = 1'b0;
        ram_ctl.addr    = bucket_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    kind_next = s_tuser;
                    key_next  = s_tdata[KW-1:0];
                    bidx_next = s_tdata[KW+BW-1:KW];
                    n_next    = n_clamp;
                    state_next = (s_tuser == dht_pkg::KIND_READ) ? S_RRD : S_MOD;
                end
            end
            S_MOD: begin
                if (mod_res.done) begin
                    bucket_next = mod_res.rem_n;
                    step_next   = mod_res.rem_m + BW'(1);
                    cnt_next    = '0;
                    state_next  = S_PRD;
                end
            end
            S_PRD: begin
                ram_ctl.rd_en = 1'b1;
                vld_q_next    = valid_reg[bucket_reg];
                state_next    = S_PCHK;
            end
            S_PCHK: begin
                if (out_free) begin
                    m_value_next    = '0;
                    m_occupied_next = 1'b0;
                    m_last_next     = 1'b1;
                    // Default: move on to the next bucket of the probe sequence.
                    state_next  = S_PRD;
                    cnt_next    = cnt_reg + SW'(1);
                    bucket_next = (sum >= n_reg) ? BW'(sum - n_reg) : sum[BW-1:0];
                    case (kind_reg)
                        dht_pkg::KIND_INSERT: begin
                            if (!vld_q_reg) begin
                                ram_ctl.wr_en          = 1'b1;
                                valid_next[bucket_reg] = 1'b1;
                                m_tvalid_next = 1'b1;
                                m_status_next = dht_pkg::ST_INSERTED;
                                m_bucket_next = bucket_reg;
                                state_next    = S_IDLE;
                            end else if (last_probe) begin
                                m_tvalid_next = 1'b1;
                                m_status_next = dht_pkg::ST_FULL;
                                m_bucket_next = '0;
                                state_next    = S_IDLE;
                            end
                        end
                        dht_pkg::KIND_SEARCH: begin
                            if (hit) begin
                                m_tvalid_next = 1'b1;
                                m_status_next = dht_pkg::ST_FOUND;
                                m_bucket_next = bucket_reg;
                                state_next    = S_IDLE;
                            end else if (last_probe) begin
                                m_tvalid_next = 1'b1;
                                m_status_next = dht_pkg::ST_NOT_FOUND;
                                m_bucket_next = '0;
                                state_next    = S_IDLE;
                            end
                        end
                        default: begin
                            m_tvalid_next = 1'b1;
                            m_status_next = dht_pkg::ST_PROBED;
                            m_bucket_next = bucket_reg;
                            m_last_next   = hit || last_probe;
                            if (hit || last_probe) begin
                                state_next = S_IDLE;
                            end
                        end
                    endcase
                end
            end
            S_RRD: begin
                ram_ctl.rd_en = 1'b1;
                ram_ctl.addr  = bidx_reg;
                vld_q_next    = valid_reg[bidx_reg];
                state_next    = S_RCHK;
            end
            S_RCHK: begin
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    m_status_next   = dht_pkg::ST_READ;
                    m_bucket_next   = bidx_reg;
                    m_value_next    = vld_q_reg ? rd_key : '0;
                    m_occupied_next = vld_q_reg;
                    m_last_next     = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            table_size_reg <= SW'(dht_pkg::CAPACITY);
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            table_size_reg <= table_size_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        bidx_reg       <= bidx_next;
        n_reg          <= n_next;
        bucket_reg     <= bucket_next;
        step_reg       <= step_next;
        cnt_reg        <= cnt_next;
        vld_q_reg      <= vld_q_next;
        m_status_reg   <= m_status_next;
        m_bucket_reg   <= m_bucket_next;
        m_value_reg    <= m_value_next;
        m_occupied_reg <= m_occupied_next;
        m_last_reg     <= m_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, m_occupied_reg, m_value_reg, m_bucket_reg};

    // The probe walk never leaves the buckets in use or runs past n probes.
    `DHT_ASSERT_IMP(a_bucket_in_range, aclk, aresetn, state_reg == S_PCHK, {1'b0, bucket_reg} < n_reg)
    `DHT_ASSERT_IMP(a_probe_count, aclk, aresetn, state_reg == S_PCHK, cnt_reg < n_reg)
    // A zero stride would revisit one bucket forever.
    `DHT_ASSERT_IMP(a_step_nonzero, aclk, aresetn, state_reg == S_PCHK, step_reg != '0)
    // A reported insert must leave its bucket marked as occupied.
    `DHT_ASSERT_NXT(a_insert_marks, aclk, aresetn, m_tvalid_next && !(m_tvalid_reg && !m_tready) && m_status_next == dht_pkg::ST_INSERTED, valid_reg[m_bucket_reg])

endmodule

/* sim/double_hash_table_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the double hashing table: stream stimulus, APB size writes, result checks.
module double_hash_table_tb;

    localparam logic [2:0] REG_TABLE_SIZE = 3'd0;
    localparam int PHASE_ITEMS = 40;

    typedef struct packed {
        logic [1:0]                kind;
        logic [dht_pkg::KEY_W-1:0] key;
        logic [dht_pkg::BKT_W-1:0] bucket_index;
    } table_op_t;

    typedef struct packed {
        logic [2:0]                status;
        logic [dht_pkg::BKT_W-1:0] bucket;
        logic [dht_pkg::KEY_W-1:0] value;
        logic                      occupied;
        logic                      last;
    } table_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    double_hash_table DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the table and its size register.
    logic [dht_pkg::KEY_W-1:0]  shadow_keys [dht_pkg::CAPACITY];
    logic                       shadow_valid [dht_pkg::CAPACITY];
    logic [dht_pkg::SIZE_W-1:0] shadow_size;

    table_op_t     pending_ops[$];
    table_result_t expected_results[$];
    logic [dht_pkg::KEY_W-1:0] inserted_keys[$];

    table_op_t in_flight;
    int  ops_queued = 0;
    int  ops_accepted = 0;
    int  results_checked = 0;
    int  mismatch_count = 0;
    int  size_writes = 0;
    int  send_gap = 0;
    int  recv_stall = 0;
    bit  steady = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #25_000_000;
        $display("Timeout with %0d results still outstanding", expected_results.size());
        $display("Mismatches found");
        $finish;
    end

    function automatic longint unsigned buckets_used();
        longint unsigned n;
        n = 64'(shadow_size);
        if (n < dht_pkg::MIN_SIZE) n = dht_pkg::MIN_SIZE;
        if (n > dht_pkg::CAPACITY) n = dht_pkg::CAPACITY;
        return n;
    endfunction

    function automatic longint unsigned probe_slot(longint unsigned k, longint unsigned i,
                                                   longint unsigned n);
        return ((k % n) + i * (1 + (k % (n - 2)))) % n;
    endfunction

    // Updates the shadow table for one accepted item and queues what it should produce.
    task automatic predict_table_op(input table_op_t op);
        longint unsigned n;
        longint unsigned k;
        longint unsigned b;
        longint unsigned i;
        logic hit;
        table_result_t r;
        n = buckets_used();
        k = 64'(op.key);
        r = '0;
        r.last = 1'b1;
        case (op.kind)
            dht_pkg::KIND_INSERT: begin
                r.status = dht_pkg::ST_FULL;
                for (i = 0; i < n; i++) begin
                    b = probe_slot(k, i, n);
                    if (!shadow_valid[b]) begin
                        shadow_valid[b] = 1'b1;
                        shadow_keys[b] = op.key;
                        r.status = dht_pkg::ST_INSERTED;
                        r.bucket = dht_pkg::BKT_W'(b);
                        break;
                    end
                end
                expected_results.push_back(r);
            end
            dht_pkg::KIND_SEARCH: begin
                r.status = dht_pkg::ST_NOT_FOUND;
                for (i = 0; i < n; i++) begin
                    b = probe_slot(k, i, n);
                    if (shadow_valid[b] && shadow_keys[b] == op.key) begin
                        r.status = dht_pkg::ST_FOUND;
                        r.bucket = dht_pkg::BKT_W'(b);
                        break;
                    end
                end
                expected_results.push_back(r);
            end
            dht_pkg::KIND_PROBE: begin
                for (i = 0; i < n; i++) begin
                    b = probe_slot(k, i, n);
                    hit = shadow_valid[b] && shadow_keys[b] == op.key;
                    r.status = dht_pkg::ST_PROBED;
                    r.bucket = dht_pkg::BKT_W'(b);
                    r.last = hit || (i + 1 == n);
                    expected_results.push_back(r);
                    if (hit) break;
                end
            end
            default: begin
                r.status = dht_pkg::ST_READ;
                r.bucket = op.bucket_index;
                if (shadow_valid[op.bucket_index]) begin
                    r.value = shadow_keys[op.bucket_index];
                    r.occupied = 1'b1;
                end
                expected_results.push_back(r);
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatch_count < 50)
            $display("ERROR at %0t: result %0d %s: got %0h, expected %0h",
                     $realtime, results_checked, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result();
        table_result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("arrived with nothing expected", 64'(m_tuser), 64'd0);
        end else begin
            want = expected_results.pop_front();
            if (m_tuser != want.status)
                report_mismatch("status", 64'(m_tuser), 64'(want.status));
            if (m_tdata[5:0] != want.bucket)
                report_mismatch("bucket", 64'(m_tdata[5:0]), 64'(want.bucket));
            if (m_tdata[36:6] != want.value)
                report_mismatch("value", 64'(m_tdata[36:6]), 64'(want.value));
            if (m_tdata[37] != want.occupied)
                report_mismatch("occupied", 64'(m_tdata[37]), 64'(want.occupied));
            if (m_tlast != want.last)
                report_mismatch("last", 64'(m_tlast), 64'(want.last));
        end
        results_checked++;
    endtask

    // Input side: one item per transfer, with random bursts of idle cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_table_op(in_flight);
                ops_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (!steady && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(1, 19) - 1;
                    s_tvalid <= 1'b0;
                end else begin
                    in_flight = pending_ops.pop_front();
                    s_tdata <= {3'b000, in_flight.bucket_index, in_flight.key};
                    s_tuser <= in_flight.kind;
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // Result side: checks every transfer and stalls in random bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_result();
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else if (!steady && $urandom_range(0, 7) == 0) begin
                recv_stall = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic queue_op(input logic [1:0] kind, input logic [dht_pkg::KEY_W-1:0] key,
                            input logic [dht_pkg::BKT_W-1:0] bidx);
        table_op_t op;
        op.kind = kind;
        op.key = key;
        op.bucket_index = bidx;
        pending_ops.push_back(op);
        if (kind == dht_pkg::KIND_INSERT) inserted_keys.push_back(key);
        ops_queued++;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (ops_accepted != ops_queued || expected_results.size() != 0);
    endtask

    task automatic write_table_size(input logic [dht_pkg::SIZE_W-1:0] sz);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_TABLE_SIZE;
        pwdata <= {25'd0, sz};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_size = sz;
        size_writes++;
        // The register reads back what was written.
        @(posedge aclk);
        if (prdata != {25'd0, sz}) report_mismatch("size readback", 64'(prdata), 64'(sz));
    endtask

    function automatic logic [dht_pkg::KEY_W-1:0] pick_key(input int from_pool_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < from_pool_pct && inserted_keys.size() > 0)
            return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        else if (r < from_pool_pct + 25)
            return dht_pkg::KEY_W'($urandom_range(0, 300));
        else
            return dht_pkg::KEY_W'($urandom());
    endfunction

    task automatic queue_random_ops(input int count);
        int r;
        longint unsigned n;
        logic [dht_pkg::BKT_W-1:0] bidx;
        n = buckets_used();
        repeat (count) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 7) bidx = dht_pkg::BKT_W'($urandom_range(0, 32'(n - 1)));
            else bidx = dht_pkg::BKT_W'($urandom());
            if (r < 35) queue_op(dht_pkg::KIND_INSERT, pick_key(25), bidx);
            else if (r < 65) queue_op(dht_pkg::KIND_SEARCH, pick_key(60), bidx);
            else if (r < 80) queue_op(dht_pkg::KIND_PROBE, pick_key(60), bidx);
            else queue_op(dht_pkg::KIND_READ, pick_key(0), bidx);
        end
    endtask

    initial begin
        int size_plan[9];
        size_plan = '{1, 3, 7, 2, 16, 127, 40, 65, 0};
        shadow_size = 7'd64;
        for (int b = 0; b < dht_pkg::CAPACITY; b++) begin
            shadow_valid[b] = 1'b0;
            shadow_keys[b] = '0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset size: empty reads, misses over the whole table, extreme keys, duplicates.
        queue_op(dht_pkg::KIND_READ, '0, 6'd0);
        queue_op(dht_pkg::KIND_READ, '1, 6'd63);
        queue_op(dht_pkg::KIND_SEARCH, '0, 6'd0);
        queue_op(dht_pkg::KIND_PROBE, 31'd12345, 6'd0);
        queue_op(dht_pkg::KIND_INSERT, '0, 6'd0);
        queue_op(dht_pkg::KIND_INSERT, '1, 6'd63);
        queue_op(dht_pkg::KIND_INSERT, '0, 6'd0);
        queue_op(dht_pkg::KIND_SEARCH, '0, 6'd0);
        queue_op(dht_pkg::KIND_SEARCH, '1, 6'd0);
        queue_op(dht_pkg::KIND_PROBE, '1, 6'd0);
        queue_op(dht_pkg::KIND_READ, '0, 6'd0);
        queue_op(dht_pkg::KIND_READ, '0, 6'd63);
        wait_drained();

        // Size below the minimum clamps to three buckets; fill it and overflow.
        write_table_size(7'd0);
        queue_op(dht_pkg::KIND_INSERT, 31'd1, 6'd0);
        queue_op(dht_pkg::KIND_INSERT, 31'd2, 6'd0);
        queue_op(dht_pkg::KIND_INSERT, 31'd3, 6'd0);
        queue_op(dht_pkg::KIND_INSERT, 31'd4, 6'd0);
        queue_op(dht_pkg::KIND_SEARCH, 31'd3, 6'd0);
        queue_op(dht_pkg::KIND_PROBE, 31'd2, 6'd0);
        queue_op(dht_pkg::KIND_PROBE, 31'd5, 6'd0);
        queue_op(dht_pkg::KIND_READ, '0, 6'd5);
        queue_op(dht_pkg::KIND_READ, '0, 6'd63);
        queue_op(dht_pkg::KIND_READ, '0, 6'd1);
        wait_drained();

        foreach (size_plan[p]) begin
            if (p == 8) begin
                size_plan[p] = $urandom_range(dht_pkg::MIN_SIZE, dht_pkg::CAPACITY);
                steady = 1'b1;
            end
            write_table_size(dht_pkg::SIZE_W'(size_plan[p]));
            queue_random_ops(PHASE_ITEMS);
            wait_drained();
        end

        // Anything arriving now is an extra result.
        repeat (200) @(posedge aclk);
        $display("Covered insert, search, probe path and bucket read over %0d size settings,",
                 size_writes);
        $display("%0d items accepted and %0d results checked.", ops_accepted, results_checked);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/dht_pkg.sv
rtl/dht_key_ram.sv
rtl/dht_mod_unit.sv
rtl/double_hash_table.sv
sim/double_hash_table_tb.sv
